// ===== sv/sle_pkg.sv =====
// Package for the sorted list engine.
// Holds request/response types, action and status codes, and the compare result type.
// No dependencies.
package sle_pkg;

    // Default number of stored entries.
    localparam int CAPACITY_DEF = 64;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // One request on the input channel.
    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    // One response on the result channel.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

    // Result of comparing a stored entry against the key.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

endpackage

// ===== sv/sle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/sle_cmp.sv =====
// Shared signed compare unit of the sorted list engine.
// Depends on sle_pkg for the compare result type.
module sle_cmp (
    input  logic [sle_pkg::VALUE_W-1:0]        entry,
    input  logic signed [sle_pkg::VALUE_W-1:0] key,
    output sle_pkg::cmp_t                      result
);

    logic signed [sle_pkg::VALUE_W-1:0] entry_s;

    // Signed ordering of a stored entry against the request key.
    assign entry_s   = $signed(entry);
    assign result.lt = (entry_s < key);
    assign result.eq = (entry_s == key);

endmodule

// ===== sv/sorted_list_engine.sv =====
// Top level of the sorted list engine: sequencer, entry memory and compare unit.
// Depends on sle_pkg, sle_ram and sle_cmp.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_req (sle_pkg::req_t)
//   m_        out        m_valid/m_ready    m_rsp (sle_pkg::rsp_t)
//
// One request at a time; s_ready is high only while the sequencer is idle.
// Entries are streamed through one RAM read port and the shared compare unit,
// one entry per cycle; an insert shifts entries from the top down, and a full insert
// or an unknown action goes straight to the finish state.
// Reset is synchronous and clears the count; the entry memory needs no clearing.
// A stalled result holds the sequencer in its finish state until taken.
module sorted_list_engine #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sle_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output sle_pkg::rsp_t m_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FWD,
        S_BWD,
        S_FINISH
    } state_t;

    state_t                             state_reg, state_next;
    logic [sle_pkg::ACTION_W-1:0]       act_reg, act_next;
    logic signed [sle_pkg::VALUE_W-1:0] key_reg, key_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [CW-1:0]                      rd_idx_reg, rd_idx_next;
    logic [AW-1:0]                      chk_idx_reg, chk_idx_next;
    logic                               chk_vld_reg, chk_vld_next;
    logic                               found_reg, found_next;
    logic [AW-1:0]                      pos_reg, pos_next;
    logic [sle_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic                               m_valid_reg, m_valid_next;
    sle_pkg::rsp_t                      m_rsp_reg, m_rsp_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [sle_pkg::VALUE_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [sle_pkg::VALUE_W-1:0] ram_rdata;
    sle_pkg::cmp_t               cmp;

    logic                        fwd_hit;
    logic                        fwd_issue;
    logic                        bwd_issue;
    logic [CW-1:0]               rd_dec;
    logic [AW+sle_pkg::POS_W-1:0]   pos_ext;
    logic [CW+sle_pkg::COUNT_W-1:0] count_ext;

    // Entry memory.
    sle_ram #(
        .WIDTH(sle_pkg::VALUE_W),
        .DEPTH(CAPACITY)
    ) u_sle_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Shared compare of the returning entry against the key.
    sle_cmp u_sle_cmp (
        .entry (ram_rdata),
        .key   (key_reg),
        .result(cmp)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    assign rd_dec    = rd_idx_reg - CW'(1);
    assign fwd_hit   = chk_vld_reg && cmp.eq;
    assign fwd_issue = (rd_idx_reg < count_reg)
                       && !((act_reg == sle_pkg::ACT_SEARCH) && fwd_hit);
    assign bwd_issue = (rd_idx_reg != '0) && !(chk_vld_reg && cmp.lt);
    assign pos_ext   = {{sle_pkg::POS_W{1'b0}}, pos_reg};
    assign count_ext = {{sle_pkg::COUNT_W{1'b0}}, count_reg};

    // Sequencer next-state logic.
    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        chk_idx_next = chk_idx_reg;
        chk_vld_next = chk_vld_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_rsp_next   = m_rsp_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = key_reg;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next     = s_req.action;
                    key_next     = s_req.value;
                    rd_idx_next  = '0;
                    chk_vld_next = 1'b0;
                    found_next   = 1'b0;
                    pos_next     = '0;
                    priority if (s_req.action == sle_pkg::ACT_INSERT) begin
                        if (count_reg == CW'(CAPACITY)) begin
                            status_next = sle_pkg::ST_FULL;
                            state_next  = S_FINISH;
                        end else begin
                            rd_idx_next = count_reg;
                            state_next  = S_BWD;
                        end
                    end else if (s_req.action == sle_pkg::ACT_REMOVE
                                 || s_req.action == sle_pkg::ACT_SEARCH) begin
                        state_next = S_FWD;
                    end else begin
                        status_next = sle_pkg::ST_MISSING;
                        state_next  = S_FINISH;
                    end
                end
            end

            // Forward scan for the first equal entry; remove shifts later ones down.
            S_FWD: begin
                ram_re       = fwd_issue;
                ram_raddr    = rd_idx_reg[AW-1:0];
                chk_vld_next = fwd_issue;
                chk_idx_next = rd_idx_reg[AW-1:0];
                if (fwd_issue) begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (chk_vld_reg) begin
                    if (found_reg && act_reg == sle_pkg::ACT_REMOVE) begin
                        ram_we    = 1'b1;
                        ram_waddr = chk_idx_reg - AW'(1);
                        ram_wdata = ram_rdata;
                    end else if (!found_reg && cmp.eq) begin
                        found_next = 1'b1;
                        pos_next   = chk_idx_reg;
                    end
                end
                if ((act_reg == sle_pkg::ACT_SEARCH) && fwd_hit) begin
                    status_next = sle_pkg::ST_DONE;
                    pos_next    = chk_idx_reg;
                    state_next  = S_FINISH;
                end else if (!chk_vld_reg && !fwd_issue) begin
                    if (found_reg) begin
                        status_next = sle_pkg::ST_DONE;
                        count_next  = count_reg - CW'(1);
                    end else begin
                        status_next = sle_pkg::ST_MISSING;
                        pos_next    = '0;
                    end
                    state_next = S_FINISH;
                end
            end

            // Backward scan from the top: shift up every entry not below the key.
            S_BWD: begin
                ram_re       = bwd_issue;
                ram_raddr    = rd_dec[AW-1:0];
                chk_vld_next = bwd_issue;
                chk_idx_next = rd_dec[AW-1:0];
                if (bwd_issue) begin
                    rd_idx_next = rd_dec;
                end
                if (chk_vld_reg && !cmp.lt) begin
                    ram_we    = 1'b1;
                    ram_waddr = chk_idx_reg + AW'(1);
                    ram_wdata = ram_rdata;
                end else if (chk_vld_reg) begin
                    ram_we      = 1'b1;
                    ram_waddr   = chk_idx_reg + AW'(1);
                    pos_next    = chk_idx_reg + AW'(1);
                    count_next  = count_reg + CW'(1);
                    status_next = sle_pkg::ST_DONE;
                    state_next  = S_FINISH;
                end else if (rd_idx_reg == '0) begin
                    ram_we      = 1'b1;
                    ram_waddr   = '0;
                    pos_next    = '0;
                    count_next  = count_reg + CW'(1);
                    status_next = sle_pkg::ST_DONE;
                    state_next  = S_FINISH;
                end
            end

            // Hand the response to the output register once it is free.
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_rsp_next.status      = status_reg;
                    m_rsp_next.position    = pos_ext[sle_pkg::POS_W-1:0];
                    m_rsp_next.entry_count = count_ext[sle_pkg::COUNT_W-1:0];
                    state_next             = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg     <= act_next;
        key_reg     <= key_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
        m_rsp_reg   <= m_rsp_next;
    end

endmodule

// ===== sv/sle_checker.sv =====
// Port-level assertions for the sorted list engine, bound to the top level.
// Depends on sle_pkg and on the sorted_list_engine ports.
module sle_port_props #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input sle_pkg::req_t s_req,
    input logic          m_valid,
    input logic          m_ready,
    input sle_pkg::rsp_t m_rsp
);

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("response changed while stalled");

    // Only one request is in work at a time.
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // A response that is not a success carries position zero.
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.status != sle_pkg::ST_DONE |-> m_rsp.position == '0)
        else $error("nonzero position on failed request");

    // A refused insert only happens with the store at capacity.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.status == sle_pkg::ST_FULL
            |-> m_rsp.entry_count == sle_pkg::COUNT_W'(CAPACITY))
        else $error("store full reported below capacity");

endmodule

bind sorted_list_engine sle_port_props #(.CAPACITY(CAPACITY)) u_sle_port_props (.*);
